// File: hw/rtl/c3f_pkg.sv
package c3f_pkg;

    // image geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int STORE_DEPTH = 1024;
    localparam int WIDTH_MAX   = (MAX_WIDTH < STORE_DEPTH) ? MAX_WIDTH : STORE_DEPTH;
    localparam int HEIGHT_MAX  = 1024;
    localparam int SIZE_MIN    = 3;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = 10;
    localparam int SIZE_W      = 11;

    // arithmetic widths
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = 24;
    localparam int ACC_W   = 16;
    localparam int BIAS_W  = 11;
    localparam int FRAC_W  = 12;
    localparam int TAPS    = 9;
    localparam int CLAMP_MAX = 255;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_TOP    = 3'd0,
        CFG_KERNEL_MIDDLE = 3'd1,
        CFG_KERNEL_BOTTOM = 3'd2,
        CFG_OFFSET_BIAS   = 3'd3,
        CFG_FRAME_WIDTH   = 3'd4,
        CFG_FRAME_HEIGHT  = 3'd5,
        CFG_COLOR_MODE    = 3'd6
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] KERNEL_MIDDLE_RST = 48'h0000_1000_0000;
    localparam logic [SIZE_W-1:0]     FRAME_SIZE_RST    = 11'd256;

    // payload of one input beat and one result beat
    typedef struct packed {
        logic [PIX_W-1:0] chan_a;
        logic [PIX_W-1:0] chan_b;
        logic [PIX_W-1:0] chan_c;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] out_a;
        logic [PIX_W-1:0] out_b;
        logic [PIX_W-1:0] out_c;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } t_pix_out;

    // window and kernel types, tap t = row*3 + col
    typedef logic [3*PIX_W-1:0]          t_pix24;
    typedef t_pix24 [TAPS-1:0]           t_win;
    typedef logic [TAPS-1:0][PIX_W-1:0]  t_chan_win;
    typedef logic [TAPS-1:0][COEF_W-1:0] t_coef_set;

    // stage load enables for the filter pipeline
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } t_stage_en;

    // per item position info that rides along the pipeline
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
        logic             rgb;
        logic             interior;
    } t_meta;

    // one tap: (acc*4096 + prod) / 4096, truncated toward zero
    function automatic logic signed [ACC_W-1:0] f_tap(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [ACC_W+FRAC_W:0] s;
        logic signed [ACC_W:0]        q;
        s = $signed({acc[ACC_W-1], acc, {FRAC_W{1'b0}}})
            + $signed({{(ACC_W+FRAC_W+1-PROD_W){prod[PROD_W-1]}}, prod});
        q = s[ACC_W+FRAC_W:FRAC_W];
        if (s[ACC_W+FRAC_W] && (s[FRAC_W-1:0] != '0)) begin
            q = q + 17'sd1;
        end
        return q[ACC_W-1:0];
    endfunction

    // add bias and clamp to 0..255
    function automatic logic [PIX_W-1:0] f_clamp(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [BIAS_W-1:0] bias
    );
        logic signed [ACC_W:0] t;
        t = $signed({acc[ACC_W-1], acc})
            + $signed({{(ACC_W+1-BIAS_W){bias[BIAS_W-1]}}, bias});
        if (t[ACC_W]) begin
            return '0;
        end else if (t > $signed((ACC_W+1)'(CLAMP_MAX))) begin
            return PIX_W'(CLAMP_MAX);
        end else begin
            return t[PIX_W-1:0];
        end
    endfunction

endpackage

// File: hw/rtl/c3f_line_window.sv
module c3f_line_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  logic [c3f_pkg::ADDR_W-1:0] i_addr,
    input  c3f_pkg::t_pix24            i_pix,
    input  logic                       i_shift,
    output c3f_pkg::t_win              o_win
);

    logic [3*c3f_pkg::PIX_W-1:0] mem_older [c3f_pkg::STORE_DEPTH];
    logic [3*c3f_pkg::PIX_W-1:0] mem_newer [c3f_pkg::STORE_DEPTH];

    c3f_pkg::t_pix24            r_up2;
    c3f_pkg::t_pix24            r_up1;
    c3f_pkg::t_pix24            r_pix;
    logic                       r_wr_en;
    logic [c3f_pkg::ADDR_W-1:0] r_wr_addr;
    c3f_pkg::t_win              r_win;
    c3f_pkg::t_win              n_win;

    // line stores: read both on an accepted beat, older store takes the
    // newer store's old word in the following cycle
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_up2             <= mem_older[i_addr];
            r_up1             <= mem_newer[i_addr];
            r_pix             <= i_pix;
            mem_newer[i_addr] <= i_pix;
        end
        if (r_wr_en) begin
            mem_older[r_wr_addr] <= r_up1;
        end
    end

    // delayed write strobe for the older store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_wr_addr <= i_addr;
        end
    end

    // window shift: columns move left, new column enters at the right
    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r*3+0] = r_win[r*3+1];
            n_win[r*3+1] = r_win[r*3+2];
        end
        n_win[2] = r_up2;
        n_win[5] = r_up1;
        n_win[8] = r_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_shift) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule

// File: hw/rtl/c3f_chan_mac.sv
module c3f_chan_mac (
    input  logic                              i_clk,
    input  c3f_pkg::t_stage_en                i_en,
    input  c3f_pkg::t_chan_win                i_win,
    input  c3f_pkg::t_coef_set                i_coef,
    input  logic signed [c3f_pkg::BIAS_W-1:0] i_bias,
    output logic [c3f_pkg::PIX_W-1:0]         o_val
);

    logic signed [c3f_pkg::PIX_W+c3f_pkg::COEF_W:0] w_mul [c3f_pkg::TAPS];
    logic signed [c3f_pkg::PROD_W-1:0] n3_prod [c3f_pkg::TAPS];
    logic signed [c3f_pkg::PROD_W-1:0] r3_prod [c3f_pkg::TAPS];
    logic signed [c3f_pkg::PROD_W-1:0] r4_prod [3:8];
    logic signed [c3f_pkg::PROD_W-1:0] r5_prod [6:8];
    logic signed [c3f_pkg::ACC_W-1:0]  n4_acc;
    logic signed [c3f_pkg::ACC_W-1:0]  r4_acc;
    logic signed [c3f_pkg::ACC_W-1:0]  n5_acc;
    logic signed [c3f_pkg::ACC_W-1:0]  r5_acc;
    logic signed [c3f_pkg::ACC_W-1:0]  w6_acc;
    logic [c3f_pkg::PIX_W-1:0]         n6_val;
    logic [c3f_pkg::PIX_W-1:0]         r6_val;

    // nine pixel by coefficient products
    always_comb begin
        for (int t = 0; t < c3f_pkg::TAPS; t++) begin
            w_mul[t]   = $signed({1'b0, i_win[t]}) * $signed(i_coef[t]);
            n3_prod[t] = w_mul[t][c3f_pkg::PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r3_prod <= n3_prod;
        end
    end

    // top row taps
    always_comb begin
        n4_acc = c3f_pkg::f_tap('0, r3_prod[0]);
        n4_acc = c3f_pkg::f_tap(n4_acc, r3_prod[1]);
        n4_acc = c3f_pkg::f_tap(n4_acc, r3_prod[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en4) begin
            r4_acc <= n4_acc;
            for (int t = 3; t < c3f_pkg::TAPS; t++) begin
                r4_prod[t] <= r3_prod[t];
            end
        end
    end

    // middle row taps
    always_comb begin
        n5_acc = c3f_pkg::f_tap(r4_acc, r4_prod[3]);
        n5_acc = c3f_pkg::f_tap(n5_acc, r4_prod[4]);
        n5_acc = c3f_pkg::f_tap(n5_acc, r4_prod[5]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en5) begin
            r5_acc <= n5_acc;
            for (int t = 6; t < c3f_pkg::TAPS; t++) begin
                r5_prod[t] <= r4_prod[t];
            end
        end
    end

    // bottom row taps, bias and clamp
    always_comb begin
        w6_acc = c3f_pkg::f_tap(r5_acc, r5_prod[6]);
        w6_acc = c3f_pkg::f_tap(w6_acc, r5_prod[7]);
        w6_acc = c3f_pkg::f_tap(w6_acc, r5_prod[8]);
        n6_val = c3f_pkg::f_clamp(w6_acc, i_bias);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en6) begin
            r6_val <= n6_val;
        end
    end

    assign o_val = r6_val;

endmodule

// File: hw/rtl/conv3x3_clamped_filter_unit.sv
// 3x3 convolution filter over a raster pixel stream.
// Input channel (i_valid / o_ready / i_data): one pixel per beat in raster
// order, gray in chan_a or RGB in chan_a..chan_c.
// Output channel (o_valid / i_ready / o_data): one beat per interior pixel,
// with the filtered channels, the center position and a frame_last flag.
// Border pixels advance the position counters but give no result.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// always ready; write only while no pixel is in flight.
// Throughput: one pixel per cycle while i_ready holds, set by the nine-tap
// pipeline that takes a new window each cycle and by the line stores, read
// once per pixel. A result reaches o_valid through the line store read,
// window load, products, then three accumulate stages, the last one also
// adding the bias and clamping into the output register.
// Stall: when i_ready is low each stage still fills empty slots; o_ready
// drops once all six stages hold a pixel. Border pixels leave after the
// window load, so they take no slot past the first stage.
// Reset (i_rst_n low, synchronous): counters, window and pipeline valids
// clear, registers return to identity kernel, 256x256 gray. Line stores are
// not cleared; the first two rows of a frame fill them before use.
module conv3x3_clamped_filter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  c3f_pkg::t_pix_in                   i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output c3f_pkg::t_pix_out                  o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [c3f_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [c3f_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [c3f_pkg::CFG_DATA_W-1:0]    r_k_top;
    logic [c3f_pkg::CFG_DATA_W-1:0]    r_k_mid;
    logic [c3f_pkg::CFG_DATA_W-1:0]    r_k_bot;
    logic signed [c3f_pkg::BIAS_W-1:0] r_bias;
    logic [c3f_pkg::SIZE_W-1:0]        r_width;
    logic [c3f_pkg::SIZE_W-1:0]        r_height;
    logic                              r_rgb;

    // position and pipeline control
    logic [c3f_pkg::POS_W-1:0] r_col;
    logic [c3f_pkg::POS_W-1:0] r_row;
    logic [c3f_pkg::POS_W-1:0] n_col;
    logic [c3f_pkg::POS_W-1:0] n_row;
    logic [c3f_pkg::SIZE_W-1:0] w_eff;
    logic [c3f_pkg::SIZE_W-1:0] h_eff;
    logic [c3f_pkg::SIZE_W-1:0] col_ext;
    logic [c3f_pkg::SIZE_W-1:0] row_ext;
    logic                       in_acc;
    logic                       cfg_acc;
    logic                       s1_move;
    logic                       rdy2, rdy3, rdy4, rdy5, rdy6;
    logic                       r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    c3f_pkg::t_meta             n1_meta;
    c3f_pkg::t_meta             r1_meta, r2_meta, r3_meta, r4_meta, r5_meta, r6_meta;
    c3f_pkg::t_stage_en         stage_en;
    c3f_pkg::t_win              win;
    c3f_pkg::t_coef_set         coefs;
    c3f_pkg::t_chan_win         win_a, win_b, win_c;
    logic [c3f_pkg::PIX_W-1:0]  val_a, val_b, val_c;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_top  <= '0;
            r_k_mid  <= c3f_pkg::KERNEL_MIDDLE_RST;
            r_k_bot  <= '0;
            r_bias   <= '0;
            r_width  <= c3f_pkg::FRAME_SIZE_RST;
            r_height <= c3f_pkg::FRAME_SIZE_RST;
            r_rgb    <= 1'b0;
        end else if (cfg_acc) begin
            unique case (c3f_pkg::t_cfg_idx'(i_cfg_index))
                c3f_pkg::CFG_KERNEL_TOP:    r_k_top  <= i_cfg_data;
                c3f_pkg::CFG_KERNEL_MIDDLE: r_k_mid  <= i_cfg_data;
                c3f_pkg::CFG_KERNEL_BOTTOM: r_k_bot  <= i_cfg_data;
                c3f_pkg::CFG_OFFSET_BIAS:   r_bias   <= i_cfg_data[c3f_pkg::BIAS_W-1:0];
                c3f_pkg::CFG_FRAME_WIDTH:   r_width  <= i_cfg_data[c3f_pkg::SIZE_W-1:0];
                c3f_pkg::CFG_FRAME_HEIGHT:  r_height <= i_cfg_data[c3f_pkg::SIZE_W-1:0];
                c3f_pkg::CFG_COLOR_MODE:    r_rgb    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        priority if (r_width < c3f_pkg::SIZE_W'(c3f_pkg::SIZE_MIN)) begin
            w_eff = c3f_pkg::SIZE_W'(c3f_pkg::SIZE_MIN);
        end else if (r_width > c3f_pkg::SIZE_W'(c3f_pkg::WIDTH_MAX)) begin
            w_eff = c3f_pkg::SIZE_W'(c3f_pkg::WIDTH_MAX);
        end else begin
            w_eff = r_width;
        end
        priority if (r_height < c3f_pkg::SIZE_W'(c3f_pkg::SIZE_MIN)) begin
            h_eff = c3f_pkg::SIZE_W'(c3f_pkg::SIZE_MIN);
        end else if (r_height > c3f_pkg::SIZE_W'(c3f_pkg::HEIGHT_MAX)) begin
            h_eff = c3f_pkg::SIZE_W'(c3f_pkg::HEIGHT_MAX);
        end else begin
            h_eff = r_height;
        end
    end

    // ready chain: a stage loads when empty or when its item moves on
    assign rdy6    = !r6_v || i_ready;
    assign rdy5    = !r5_v || rdy6;
    assign rdy4    = !r4_v || rdy5;
    assign rdy3    = !r3_v || rdy4;
    assign rdy2    = !r2_v || rdy3;
    assign o_ready = !r1_v || rdy2;
    assign in_acc  = i_valid && o_ready;
    assign s1_move = r1_v && rdy2;

    assign stage_en = '{en3: rdy3, en4: rdy4, en5: rdy5, en6: rdy6};

    // position counters and per pixel info
    always_comb begin
        col_ext = {1'b0, r_col};
        row_ext = {1'b0, r_row};
        n1_meta.row  = r_row - c3f_pkg::POS_W'(1);
        n1_meta.col  = r_col - c3f_pkg::POS_W'(1);
        n1_meta.last = (row_ext == h_eff - 1'b1) && (col_ext == w_eff - 1'b1);
        n1_meta.rgb  = r_rgb;
        n1_meta.interior = (r_row >= c3f_pkg::POS_W'(2)) && (r_col >= c3f_pkg::POS_W'(2))
                           && (row_ext < h_eff) && (col_ext < w_eff);
        n_col = r_col + c3f_pkg::POS_W'(1);
        n_row = r_row;
        if (col_ext >= w_eff - 1'b1) begin
            n_col = '0;
            if (row_ext >= h_eff - 1'b1) begin
                n_row = '0;
            end else begin
                n_row = r_row + c3f_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage valids; border pixels leave after the window load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            if (o_ready) begin
                r1_v <= i_valid;
            end
            if (rdy2) begin
                r2_v <= r1_v && r1_meta.interior;
            end
            if (rdy3) begin
                r3_v <= r2_v;
            end
            if (rdy4) begin
                r4_v <= r3_v;
            end
            if (rdy5) begin
                r5_v <= r4_v;
            end
            if (rdy6) begin
                r6_v <= r5_v;
            end
        end
    end

    // position info follows its pixel
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_meta <= n1_meta;
        end
        if (rdy2) begin
            r2_meta <= r1_meta;
        end
        if (rdy3) begin
            r3_meta <= r2_meta;
        end
        if (rdy4) begin
            r4_meta <= r3_meta;
        end
        if (rdy5) begin
            r5_meta <= r4_meta;
        end
        if (rdy6) begin
            r6_meta <= r5_meta;
        end
    end

    c3f_line_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (in_acc),
        .i_addr  (r_col[c3f_pkg::ADDR_W-1:0]),
        .i_pix   ({i_data.chan_c, i_data.chan_b, i_data.chan_a}),
        .i_shift (s1_move),
        .o_win   (win)
    );

    // kernel taps and per channel windows
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            coefs[c]     = r_k_top[c*c3f_pkg::COEF_W +: c3f_pkg::COEF_W];
            coefs[3 + c] = r_k_mid[c*c3f_pkg::COEF_W +: c3f_pkg::COEF_W];
            coefs[6 + c] = r_k_bot[c*c3f_pkg::COEF_W +: c3f_pkg::COEF_W];
        end
        for (int t = 0; t < c3f_pkg::TAPS; t++) begin
            win_a[t] = win[t][c3f_pkg::PIX_W-1:0];
            win_b[t] = win[t][2*c3f_pkg::PIX_W-1:c3f_pkg::PIX_W];
            win_c[t] = win[t][3*c3f_pkg::PIX_W-1:2*c3f_pkg::PIX_W];
        end
    end

    c3f_chan_mac u_mac_a (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_win  (win_a),
        .i_coef (coefs),
        .i_bias (r_bias),
        .o_val  (val_a)
    );

    c3f_chan_mac u_mac_b (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_win  (win_b),
        .i_coef (coefs),
        .i_bias (r_bias),
        .o_val  (val_b)
    );

    c3f_chan_mac u_mac_c (
        .i_clk  (i_clk),
        .i_en   (stage_en),
        .i_win  (win_c),
        .i_coef (coefs),
        .i_bias (r_bias),
        .o_val  (val_c)
    );

    // result beat
    assign o_valid             = r6_v;
    assign o_data.out_a        = val_a;
    assign o_data.out_b        = r6_meta.rgb ? val_b : '0;
    assign o_data.out_c        = r6_meta.rgb ? val_c : '0;
    assign o_data.out_row      = r6_meta.row;
    assign o_data.out_col      = r6_meta.col;
    assign o_data.frame_last   = r6_meta.last;

`ifndef SYNTHESIS
    // a pixel on the last column wraps the column counter
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ({1'b0, r_col} >= w_eff - 1'b1)) |=> (r_col == '0))
        else $error("column counter did not wrap at end of row");

    // counters move only on accepted pixel beats
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> ($stable(r_col) && $stable(r_row)))
        else $error("position counters moved without a pixel beat");

    // results only come from interior pixels
    a_out_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.out_row != '0) && (o_data.out_col != '0)))
        else $error("result beat for a border pixel");

    // border pixels never enter the filter stages
    a_border_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && !r1_meta.interior) |=> !r2_v)
        else $error("border pixel entered the filter pipeline");
`endif

endmodule
